FILE: src/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types, register indexes and helpers for the nearest-target tracker.
// ----------------------------------------------------------------------------
package nts_pkg;

    // Configuration register indexes.
    localparam logic [3:0] CFG_FILTER_ALPHA     = 4'd0;
    localparam logic [3:0] CFG_LOST_FRAME_LIMIT = 4'd1;
    localparam logic [3:0] CFG_FRAME_WIDTH      = 4'd2;
    localparam logic [3:0] CFG_FRAME_HEIGHT     = 4'd3;

    // Unity weight of the smoothing filter (Q1.8).
    localparam logic [8:0] ALPHA_ONE = 9'd256;

    // Item codes on the input channel.
    localparam logic OP_DETECTION    = 1'b0;
    localparam logic OP_END_OF_FRAME = 1'b1;

    // Class value that marks "nothing tracked".
    localparam logic signed [8:0] CLASS_NONE = -9'sd1;

    // Register file contents.
    typedef struct packed {
        logic [8:0]  filter_alpha;
        logic [7:0]  lost_frame_limit;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } t_cfg;

    // Word passed from the front end to the tracker at each end of frame.
    typedef struct packed {
        logic        have;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  cls;
        logic [15:0] confidence;
    } t_frame;

    // Status of the frame queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One result word.
    typedef struct packed {
        logic               tracking;
        logic signed [13:0] offset_x;
        logic signed [13:0] offset_y;
        logic signed [8:0]  target_class;
        logic [15:0]        target_confidence;
        logic [8:0]         missed_frames;
        logic [15:0]        smoothed_x;
        logic [15:0]        smoothed_y;
        logic [15:0]        latest_x;
        logic [15:0]        latest_y;
    } t_result;

    // Frame center in 1/16 pixel: half the size in pixels times 16.
    function automatic logic [14:0] center_units(input logic [11:0] size_px);
        return {size_px, 3'b000};
    endfunction

endpackage

FILE: src/nearest_target_smoothing_tracker.sv
// ----------------------------------------------------------------------------
// nearest_target_smoothing_tracker
// Picks the detection nearest the frame center in each frame and tracks it
// with an exponentially smoothed center and a lost-frame buffer.
//
//   Channel   Handshake              Word
//   input     i_push / o_full        op, detection center, class, confidence
//   result    o_empty / i_pop        tracking state, offsets, smoothed center
//   config    i_cfg_valid / ready    register index, write data
//
// One word is accepted per cycle unless o_full is high; detection words pass through
// the squaring stage and the compare against the best candidate.
// An end-of-frame word passes the square stage, the frame queue, the state update
// stage and the result stage, one frame per cycle while the result queue has room.
// Reset is synchronous and active low; the queues empty and the tracked
// class returns to none. A full result queue stalls the tracker, and a full
// frame queue stalls the front end only on end-of-frame words.
// ----------------------------------------------------------------------------
module nearest_target_smoothing_tracker import nts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_op,
    input  logic [15:0]        i_det_x,
    input  logic [15:0]        i_det_y,
    input  logic [7:0]         i_det_class,
    input  logic [15:0]        i_det_confidence,
    // Result channel
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_tracking,
    output logic signed [13:0] o_offset_x,
    output logic signed [13:0] o_offset_y,
    output logic signed [8:0]  o_target_class,
    output logic [15:0]        o_target_confidence,
    output logic [8:0]         o_missed_frames,
    output logic [15:0]        o_smoothed_x,
    output logic [15:0]        o_smoothed_y,
    output logic [15:0]        o_latest_x,
    output logic [15:0]        o_latest_y,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    t_cfg      r_cfg;
    logic      w_fq_push;
    logic      w_fq_pop;
    t_frame    w_fq_in;
    t_frame    w_fq_out;
    t_q_status w_fq_status;
    t_result   w_result;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_alpha     <= 9'd128;
            r_cfg.lost_frame_limit <= 8'd5;
            r_cfg.frame_width      <= 12'd640;
            r_cfg.frame_height     <= 12'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FILTER_ALPHA: begin
                    r_cfg.filter_alpha <= i_cfg_data[8:0];
                end
                CFG_LOST_FRAME_LIMIT: begin
                    r_cfg.lost_frame_limit <= i_cfg_data[7:0];
                end
                CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: distance and candidate selection.
    nts_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_op             (i_op),
        .i_det_x          (i_det_x),
        .i_det_y          (i_det_y),
        .i_det_class      (i_det_class),
        .i_det_confidence (i_det_confidence),
        .o_fq_push        (w_fq_push),
        .o_fq_word        (w_fq_in),
        .i_fq_status      (w_fq_status)
    );

    // Frame queue between the two halves.
    nts_frame_queue u_frame_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fq_push),
        .i_word   (w_fq_in),
        .i_pop    (w_fq_pop),
        .o_word   (w_fq_out),
        .o_status (w_fq_status)
    );

    // Tracker and result queue.
    nts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_frame     (w_fq_out),
        .i_fq_status (w_fq_status),
        .o_fq_pop    (w_fq_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (w_result)
    );

    assign o_tracking          = w_result.tracking;
    assign o_offset_x          = w_result.offset_x;
    assign o_offset_y          = w_result.offset_y;
    assign o_target_class      = w_result.target_class;
    assign o_target_confidence = w_result.target_confidence;
    assign o_missed_frames     = w_result.missed_frames;
    assign o_smoothed_x        = w_result.smoothed_x;
    assign o_smoothed_y        = w_result.smoothed_y;
    assign o_latest_x          = w_result.latest_x;
    assign o_latest_y          = w_result.latest_y;

    // The front end never pushes a frame word into a full queue.
    a_fq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq_push |-> !w_fq_status.full)
        else $error("frame word pushed into a full queue");

    // The tracker never takes a frame word from an empty queue.
    a_fq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq_pop |-> !w_fq_status.empty)
        else $error("frame word taken from an empty queue");

    // A lost track reports no class and no missed frames.
    a_lost_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_tracking) |-> (o_target_class == CLASS_NONE)
                                      && (o_missed_frames == 9'd0))
        else $error("lost track still holds state");

    // Without a held class the offsets are zero.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_target_class == CLASS_NONE)) |->
            (o_offset_x == 14'sd0) && (o_offset_y == 14'sd0))
        else $error("offset reported with nothing tracked");

endmodule

FILE: src/nts_front.sv
// ----------------------------------------------------------------------------
// nts_front
// Accepts input words, squares the distance to the frame center and keeps
// the nearest detection of the current frame; hands it on at end of frame.
// ----------------------------------------------------------------------------
module nts_front import nts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [15:0] i_det_x,
    input  logic [15:0] i_det_y,
    input  logic [7:0]  i_det_class,
    input  logic [15:0] i_det_confidence,
    output logic        o_fq_push,
    output t_frame      o_fq_word,
    input  t_q_status   i_fq_status
);

    // Stage registers.
    logic        r_s1_valid;
    logic        r_s1_op;
    logic [15:0] r_s1_x;
    logic [15:0] r_s1_y;
    logic [7:0]  r_s1_class;
    logic [15:0] r_s1_conf;
    logic [31:0] r_s1_sq_x;
    logic [31:0] r_s1_sq_y;

    // Candidate of the current frame.
    logic        r_have;
    logic [32:0] r_best;
    logic [15:0] r_cand_x;
    logic [15:0] r_cand_y;
    logic [7:0]  r_cand_class;
    logic [15:0] r_cand_conf;

    logic               w_advance;
    logic               w_accept;
    logic signed [17:0] w_dx;
    logic signed [17:0] w_dy;
    logic signed [35:0] w_sq_x;
    logic signed [35:0] w_sq_y;
    logic [32:0]        w_dist;
    logic               w_take;

    // The stage moves on unless an end-of-frame word meets a full queue.
    assign w_advance = r_s1_valid && ((r_s1_op == OP_DETECTION) || !i_fq_status.full);
    assign o_full    = r_s1_valid && !w_advance;
    assign w_accept  = i_push && !o_full;

    // Offsets from the frame center and their squares.
    assign w_dx   = $signed({2'b00, i_det_x}) - $signed({3'b000, center_units(i_cfg.frame_width)});
    assign w_dy   = $signed({2'b00, i_det_y})
                  - $signed({3'b000, center_units(i_cfg.frame_height)});
    assign w_sq_x = w_dx * w_dx;
    assign w_sq_y = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op    <= i_op;
            r_s1_x     <= i_det_x;
            r_s1_y     <= i_det_y;
            r_s1_class <= i_det_class;
            r_s1_conf  <= i_det_confidence;
            r_s1_sq_x  <= w_sq_x[31:0];
            r_s1_sq_y  <= w_sq_y[31:0];
        end
    end

    // Compare with the best so far; the earlier detection wins a tie.
    assign w_dist = {1'b0, r_s1_sq_x} + {1'b0, r_s1_sq_y};
    assign w_take = !r_have || (w_dist < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_advance) begin
            if (r_s1_op == OP_END_OF_FRAME) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && (r_s1_op == OP_DETECTION) && w_take) begin
            r_best       <= w_dist;
            r_cand_x     <= r_s1_x;
            r_cand_y     <= r_s1_y;
            r_cand_class <= r_s1_class;
            r_cand_conf  <= r_s1_conf;
        end
    end

    // Hand the frame's candidate to the tracker.
    assign o_fq_push            = w_advance && (r_s1_op == OP_END_OF_FRAME);
    assign o_fq_word.have       = r_have;
    assign o_fq_word.x          = r_cand_x;
    assign o_fq_word.y          = r_cand_y;
    assign o_fq_word.cls        = r_cand_class;
    assign o_fq_word.confidence = r_cand_conf;

endmodule

FILE: src/nts_frame_queue.sv
// ----------------------------------------------------------------------------
// nts_frame_queue
// Four-word queue of frame candidates between the front end and the tracker.
// ----------------------------------------------------------------------------
module nts_frame_queue import nts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_frame    i_word,
    input  logic      i_pop,
    output t_frame    o_word,
    output t_q_status o_status
);

    t_frame     r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_status.full  = (r_cnt == 3'd4);
    assign o_status.empty = (r_cnt == 3'd0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 3'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    assign o_word = r_mem[r_rd];

endmodule

FILE: src/nts_back.sv
// ----------------------------------------------------------------------------
// nts_back
// Tracker: applies each frame's candidate to the tracked state, smooths the
// center, forms the result word and queues it for the output.
// ----------------------------------------------------------------------------
module nts_back import nts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_frame    i_frame,
    input  t_q_status i_fq_status,
    output logic      o_fq_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_result   o_result
);

    // Tracked state.
    logic [15:0]       r_filt_x;
    logic [15:0]       r_filt_y;
    logic [15:0]       r_held_x;
    logic [15:0]       r_held_y;
    logic signed [8:0] r_held_class;
    logic [15:0]       r_held_conf;
    logic [8:0]        r_miss;

    // Result stage and result queue.
    logic       r_s2_valid;
    logic       r_s2_tracking;
    t_result    r_rq [2];
    logic       r_rq_wr;
    logic       r_rq_rd;
    logic [1:0] r_rq_cnt;

    logic               w_s2_push;
    logic               w_rq_pop;
    logic [8:0]         w_alpha;
    logic signed [16:0] w_diff_x;
    logic signed [16:0] w_diff_y;
    logic signed [26:0] w_prod_x;
    logic signed [26:0] w_prod_y;
    logic signed [18:0] w_sum_x;
    logic signed [18:0] w_sum_y;
    logic               w_filt_zero;
    logic [8:0]         w_miss_inc;
    logic               w_within;
    logic signed [17:0] w_cdx;
    logic signed [17:0] w_cdy;
    logic signed [17:0] w_adj_x;
    logic signed [17:0] w_adj_y;
    logic signed [17:0] w_off_x;
    logic signed [17:0] w_off_y;
    t_result            w_result;

    // Flow control: the result stage drains into the queue, the state stage
    // takes a frame when the result stage is free or draining.
    assign w_s2_push = r_s2_valid && (r_rq_cnt != 2'd2);
    assign o_fq_pop  = !i_fq_status.empty && (!r_s2_valid || w_s2_push);
    assign o_empty   = (r_rq_cnt == 2'd0);
    assign w_rq_pop  = i_pop && !o_empty;

    // Smoothing: old + floor(alpha * (raw - old) / 256).
    assign w_alpha     = (i_cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.filter_alpha;
    assign w_diff_x    = $signed({1'b0, i_frame.x}) - $signed({1'b0, r_filt_x});
    assign w_diff_y    = $signed({1'b0, i_frame.y}) - $signed({1'b0, r_filt_y});
    assign w_prod_x    = $signed({1'b0, w_alpha}) * w_diff_x;
    assign w_prod_y    = $signed({1'b0, w_alpha}) * w_diff_y;
    assign w_sum_x     = $signed({3'b000, r_filt_x}) + $signed(w_prod_x[26:8]);
    assign w_sum_y     = $signed({3'b000, r_filt_y}) + $signed(w_prod_y[26:8]);
    assign w_filt_zero = (r_filt_x == 16'd0) && (r_filt_y == 16'd0);

    // Missed-frame count after this frame.
    assign w_miss_inc = r_miss + 9'd1;
    assign w_within   = (w_miss_inc <= {1'b0, i_cfg.lost_frame_limit});

    // State update, one frame per cycle while a frame waits and the result stage is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_x     <= 16'd0;
            r_filt_y     <= 16'd0;
            r_held_x     <= 16'd0;
            r_held_y     <= 16'd0;
            r_held_class <= CLASS_NONE;
            r_held_conf  <= 16'd0;
            r_miss       <= 9'd0;
        end else if (o_fq_pop) begin
            if (i_frame.have) begin
                r_miss       <= 9'd0;
                r_held_class <= $signed({1'b0, i_frame.cls});
                r_held_conf  <= i_frame.confidence;
                r_held_x     <= i_frame.x;
                r_held_y     <= i_frame.y;
                if (w_filt_zero) begin
                    r_filt_x <= i_frame.x;
                    r_filt_y <= i_frame.y;
                end else begin
                    r_filt_x <= w_sum_x[15:0];
                    r_filt_y <= w_sum_y[15:0];
                end
            end else if (w_within) begin
                r_miss <= w_miss_inc;
            end else begin
                r_filt_x     <= 16'd0;
                r_filt_y     <= 16'd0;
                r_held_x     <= 16'd0;
                r_held_y     <= 16'd0;
                r_held_class <= CLASS_NONE;
                r_held_conf  <= 16'd0;
                r_miss       <= 9'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_fq_pop) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_push) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fq_pop) begin
            r_s2_tracking <= i_frame.have || w_within;
        end
    end

    // Offsets in whole pixels, truncated toward zero.
    assign w_cdx   = $signed({2'b00, r_filt_x})
                   - $signed({3'b000, center_units(i_cfg.frame_width)});
    assign w_cdy   = $signed({2'b00, r_filt_y})
                   - $signed({3'b000, center_units(i_cfg.frame_height)});
    assign w_adj_x = w_cdx + (w_cdx[17] ? 18'sd15 : 18'sd0);
    assign w_adj_y = w_cdy + (w_cdy[17] ? 18'sd15 : 18'sd0);
    assign w_off_x = w_adj_x >>> 4;
    assign w_off_y = w_adj_y >>> 4;

    // Result word from the state just written.
    always_comb begin
        w_result.tracking          = r_s2_tracking;
        w_result.offset_x          = 14'sd0;
        w_result.offset_y          = 14'sd0;
        if (r_held_class != CLASS_NONE) begin
            w_result.offset_x = w_off_x[13:0];
            w_result.offset_y = w_off_y[13:0];
        end
        w_result.target_class      = r_held_class;
        w_result.target_confidence = r_held_conf;
        w_result.missed_frames     = r_miss;
        w_result.smoothed_x        = r_filt_x;
        w_result.smoothed_y        = r_filt_y;
        w_result.latest_x          = r_held_x;
        w_result.latest_y          = r_held_y;
    end

    // Result queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (w_s2_push) begin
                r_rq_wr <= ~r_rq_wr;
            end
            if (w_rq_pop) begin
                r_rq_rd <= ~r_rq_rd;
            end
            if (w_s2_push && !w_rq_pop) begin
                r_rq_cnt <= r_rq_cnt + 2'd1;
            end else if (w_rq_pop && !w_s2_push) begin
                r_rq_cnt <= r_rq_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_push) begin
            r_rq[r_rq_wr] <= w_result;
        end
    end

    assign o_result = r_rq[r_rq_rd];

endmodule
